### rtl/core/focpi_pkg.sv
// package for the foc pi step core: types, constants, sine table function
`timescale 1ns / 1ps
package focpi_pkg;

    localparam int SineTableDepth = 256;
    localparam int NumRegs = 6;
    localparam int RegIdxW = 3;

    localparam logic [RegIdxW-1:0] REG_SPEED_TARGET = 3'd0;
    localparam logic [RegIdxW-1:0] REG_D_TARGET     = 3'd1;
    localparam logic [RegIdxW-1:0] REG_Q_KP         = 3'd2;
    localparam logic [RegIdxW-1:0] REG_Q_KI         = 3'd3;
    localparam logic [RegIdxW-1:0] REG_D_KP         = 3'd4;
    localparam logic [RegIdxW-1:0] REG_D_KI         = 3'd5;

    localparam logic [15:0] SpeedTargetRst = 16'd1000;
    localparam logic [15:0] DTargetRst     = 16'd0;
    localparam logic [15:0] KpRst          = 16'd256;
    localparam logic [15:0] KiRst          = 16'd26;

    localparam logic signed [17:0] Inv3Q16     = 18'sd21845;
    localparam logic signed [17:0] InvSqrt3Q16 = 18'sd37837;
    localparam logic [15:0] SinOne = 16'd32767;

    // multiplier operand selects
    typedef enum logic [2:0] {
        MUL_ALPHA, MUL_BETA, MUL_AC, MUL_BS, MUL_QP, MUL_QI, MUL_DP, MUL_DI
    } t_mul_sel;

    // quarter-wave sine entry k of a table of the given depth, Q1.15
    // (elaboration-time constant generation only)
    function automatic logic [15:0] rom_entry(input int unsigned k, input int unsigned depth);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] acc;
        logic [63:0] r;
        // depth is a power of two, so dividing by twice the depth is a shift
        x = (64'd3373259426 * 64'(k)) >> ($clog2(depth) + 1);
        x2 = (x * x) >> 30;
        acc = $signed(x);
        // taylor terms up to x^13, each built from the previous one
        term = ((x * x2) >> 30) / 64'd6;
        acc = acc - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        acc = acc + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        acc = acc - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        acc = acc + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        acc = acc - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        acc = acc + $signed(term);
        if (acc < 0) acc = 0;
        r = (64'(acc) + 64'd16384) >> 15;
        if (r > 64'd32767) r = 64'd32767;
        return r[15:0];
    endfunction

endpackage

### rtl/core/focpi_sine.sv
// quarter-wave sine/cosine lookup with registered output
`timescale 1ns / 1ps
module focpi_sine #(
    parameter int SINE_TABLE_DEPTH = focpi_pkg::SineTableDepth
) (
    input  logic                i_clk,
    input  logic [15:0]         i_angle,
    output logic signed [16:0]  o_sin,
    output logic signed [16:0]  o_cos
);
    localparam int AW = $clog2(SINE_TABLE_DEPTH);
    localparam int PW = AW + 2;

    // whole quarter-wave table packed into one constant, entry k at bit 16k
    function automatic logic [16*SINE_TABLE_DEPTH-1:0] build_rom();
        logic [16*SINE_TABLE_DEPTH-1:0] t;
        t = '0;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            t[16*k +: 16] = focpi_pkg::rom_entry(k, SINE_TABLE_DEPTH);
        end
        return t;
    endfunction

    localparam logic [16*SINE_TABLE_DEPTH-1:0] SineRom = build_rom();

    logic [PW-1:0] w_p;
    logic [PW-1:0] w_pc;

    function automatic logic signed [16:0] lookup(input logic [PW-1:0] p);
        logic [AW-1:0] r;
        logic [AW-1:0] nr;
        logic [15:0] mag;
        r = p[AW-1:0];
        nr = AW'(0) - r;
        if (p[AW]) mag = (r == '0) ? focpi_pkg::SinOne : SineRom[16*int'(nr) +: 16];
        else mag = SineRom[16*int'(r) +: 16];
        return p[AW+1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    assign w_p  = i_angle[15 -: PW];
    assign w_pc = w_p + PW'(SINE_TABLE_DEPTH);

    always_ff @(posedge i_clk) begin
        o_sin <= lookup(w_p);
        o_cos <= lookup(w_pc);
    end
endmodule

### rtl/core/focpi_mul.sv
// shared 34x18 signed multiplier with registered product
`timescale 1ns / 1ps
module focpi_mul (
    input  logic                i_clk,
    input  logic signed [33:0]  i_a,
    input  logic signed [17:0]  i_b,
    output logic signed [51:0]  o_p
);
    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end
endmodule

### rtl/core/foc_pi_current_speed_step_core.sv
// top level of the foc pi current/speed control step core
`timescale 1ns / 1ps
// One control step per input word: Clarke, Park, two PI loops with 32-bit
// saturating integrators, inverse Park and 16-bit output saturation. All
// products go through one shared registered multiplier (34x18) sequenced by
// a one-hot state machine; the 32x17 inverse Park products are split into two
// partial products each. An input word is taken when idle; the result word
// is written to an output register at the end of the sequence, and the core
// returns to idle and takes the next word only after that result has been
// taken, so no new word is accepted while a step runs or its output stalls.
module foc_pi_current_speed_step_core #(
    parameter int SINE_TABLE_DEPTH = focpi_pkg::SineTableDepth
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [15:0]  i_phase_a_current,
    input  logic signed [15:0]  i_phase_b_current,
    input  logic signed [15:0]  i_phase_c_current,
    input  logic [15:0]         i_rotor_angle,
    input  logic signed [15:0]  i_measured_speed,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [15:0]  o_alpha_command,
    output logic signed [15:0]  o_beta_command
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_CLK   = 11'b00000000010,
        S_ALB   = 11'b00000000100,
        S_PARK  = 11'b00000001000,
        S_ID    = 11'b00000010000,
        S_PI    = 11'b00000100000,
        S_PIS   = 11'b00001000000,
        S_CMD   = 11'b00010000000,
        S_INV   = 11'b00100000000,
        S_FIN   = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic [4:0] r_cnt, n_cnt;

    logic signed [15:0] r_speed_target, r_d_target;
    logic [15:0] r_q_kp, r_q_ki, r_d_kp, r_d_ki;
    logic signed [31:0] r_q_sum, r_d_sum;

    logic signed [15:0] r_ia, r_ib, r_ic, r_speed;
    logic [15:0] r_angle;
    logic signed [16:0] w_sin, w_cos;
    logic signed [33:0] r_alpha, r_beta;
    logic signed [63:0] r_acc;
    logic signed [16:0] r_serr;
    logic signed [17:0] r_derr;
    logic signed [31:0] r_qcmd, r_dcmd;
    logic signed [15:0] r_a_out, r_b_out;
    logic r_ovalid;

    logic signed [33:0] w_ma;
    logic signed [17:0] w_mb;
    logic signed [51:0] w_prod;

    focpi_sine #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sine (
        .i_clk   (i_clk),
        .i_angle (r_angle),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    focpi_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
        if (v < -64'sh80000000) return -32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        if (v > 64'sd32767) return 16'sh7FFF;
        if (v < -64'sd32768) return -16'sh8000;
        return v[15:0];
    endfunction

    // operand schedule by counter value: multiply issued at the listed value, product registered
    // 0 alpha, 1 beta, 3 alpha*cos, 4 beta*sin, 6 qkp*e, 7 qki*sum,
    // 8 dkp*e, 9 dki*sum, 11.. inverse park partial products
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_cnt)
            5'd0: begin
                w_ma = 34'(2 * 34'(r_ia) - 34'(r_ib) - 34'(r_ic));
                w_mb = focpi_pkg::Inv3Q16;
            end
            5'd1: begin
                w_ma = 34'(34'(r_ib) - 34'(r_ic));
                w_mb = focpi_pkg::InvSqrt3Q16;
            end
            5'd3: begin w_ma = r_alpha; w_mb = 18'(w_cos); end
            5'd4: begin w_ma = r_beta;  w_mb = 18'(w_sin); end
            5'd6: begin w_ma = 34'(r_serr); w_mb = $signed({2'b00, r_q_kp}); end
            5'd7: begin w_ma = 34'(r_q_sum); w_mb = $signed({2'b00, r_q_ki}); end
            5'd8: begin w_ma = 34'(r_derr); w_mb = $signed({2'b00, r_d_kp}); end
            5'd9: begin w_ma = 34'(r_d_sum); w_mb = $signed({2'b00, r_d_ki}); end
            // low/high halves of 32-bit commands times trig
            5'd11: begin w_ma = $signed({18'd0, r_dcmd[15:0]}); w_mb = 18'(w_cos); end
            5'd12: begin w_ma = 34'($signed(r_dcmd[31:16])); w_mb = 18'(w_cos); end
            5'd13: begin w_ma = $signed({18'd0, r_qcmd[15:0]}); w_mb = 18'(w_sin); end
            5'd14: begin w_ma = 34'($signed(r_qcmd[31:16])); w_mb = 18'(w_sin); end
            5'd15: begin w_ma = $signed({18'd0, r_dcmd[15:0]}); w_mb = 18'(w_sin); end
            5'd16: begin w_ma = 34'($signed(r_dcmd[31:16])); w_mb = 18'(w_sin); end
            5'd17: begin w_ma = $signed({18'd0, r_qcmd[15:0]}); w_mb = 18'(w_cos); end
            5'd18: begin w_ma = 34'($signed(r_qcmd[31:16])); w_mb = 18'(w_cos); end
            default: ;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_alpha_command = r_a_out;
    assign o_beta_command = r_b_out;

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        unique case (r_state)
            S_IDLE: if (i_valid) begin n_state = S_CLK; n_cnt = '0; end
            S_OUT: if (!r_ovalid) n_state = S_IDLE;
            default: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd19) n_state = S_OUT;
                else n_state = S_CLK;
            end
        endcase
    end

    logic signed [63:0] w_p64;
    assign w_p64 = 64'(w_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_ovalid <= 1'b0;
            r_speed_target <= focpi_pkg::SpeedTargetRst;
            r_d_target <= focpi_pkg::DTargetRst;
            r_q_kp <= focpi_pkg::KpRst;
            r_q_ki <= focpi_pkg::KiRst;
            r_d_kp <= focpi_pkg::KpRst;
            r_d_ki <= focpi_pkg::KiRst;
            r_q_sum <= '0;
            r_d_sum <= '0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    focpi_pkg::REG_SPEED_TARGET: r_speed_target <= i_cfg_data;
                    focpi_pkg::REG_D_TARGET:     r_d_target <= i_cfg_data;
                    focpi_pkg::REG_Q_KP:         r_q_kp <= i_cfg_data;
                    focpi_pkg::REG_Q_KI:         r_q_ki <= i_cfg_data;
                    focpi_pkg::REG_D_KP:         r_d_kp <= i_cfg_data;
                    focpi_pkg::REG_D_KI:         r_d_ki <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_CLK) begin
                // both errors are registered at count 5
                if (r_cnt == 5'd6) begin
                    r_q_sum <= sat32(64'(r_q_sum) + 64'(r_serr));
                    r_d_sum <= sat32(64'(r_d_sum) + 64'(r_derr));
                end
                if (r_cnt == 5'd19) r_ovalid <= 1'b1;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_ia <= i_phase_a_current;
            r_ib <= i_phase_b_current;
            r_ic <= i_phase_c_current;
            r_angle <= i_rotor_angle;
            r_speed <= i_measured_speed;
        end
        if (r_state == S_CLK) begin
            case (r_cnt)
                5'd1: r_alpha <= 34'(w_prod >>> 16);
                5'd2: r_beta <= 34'(w_prod >>> 16);
                5'd4: r_acc <= w_p64;
                5'd5: begin
                    // d error from floor((a*c + b*s) >> 15)
                    r_derr <= 18'(64'(r_d_target) - ((r_acc + w_p64) >>> 15));
                    r_serr <= 17'(r_speed_target) - 17'(r_speed);
                end
                5'd7: r_acc <= w_p64;
                5'd8: r_qcmd <= sat32((r_acc + w_p64) <<< 4);
                5'd9: r_acc <= w_p64;
                5'd10: r_dcmd <= sat32((r_acc + w_p64) >>> 8);
                5'd12: r_acc <= w_p64;
                5'd13: r_acc <= r_acc + (w_p64 <<< 16);
                5'd14: r_acc <= r_acc - w_p64;
                5'd15: r_a_out <= sat16((r_acc - (w_p64 <<< 16)) >>> 15);
                5'd16: r_acc <= w_p64;
                5'd17: r_acc <= r_acc + (w_p64 <<< 16);
                5'd18: r_acc <= r_acc + w_p64;
                5'd19: r_b_out <= sat16((r_acc + (w_p64 <<< 16)) >>> 15);
                default: ;
            endcase
        end
    end
endmodule
